// ===== rtl/wavetable_sine_vco_unit_macros.svh =====
// assertion helpers for the oscillator
`ifndef WAVETABLE_SINE_VCO_UNIT_MACROS_SVH
`define WAVETABLE_SINE_VCO_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define WSV_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("oscillator check failed");

// next-cycle implication, clocked on clk, off during rst
`define WSV_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("oscillator check failed");

`endif

// ===== rtl/wsv_pkg.sv =====
package wsv_pkg;

  // default sizes
  localparam int VOICES_DEF       = 16;
  localparam int WAVE_ENTRIES_DEF = 1024;

  // register indexes
  typedef enum logic [2:0] {
    REG_BASE_PITCH   = 3'd0,
    REG_PHASE_OFFSET = 3'd1,
    REG_VOLUME       = 3'd2,
    REG_FM_DEPTH     = 3'd3,
    REG_PM_DEPTH     = 3'd4,
    REG_VM_DEPTH     = 3'd5,
    REG_STEP_PER_HZ  = 3'd6
  } reg_idx_t;

  // register reset values
  localparam logic [22:0] BASE_PITCH_RST  = 23'd66976;
  localparam logic [15:0] VOLUME_RST      = 16'd16384;
  localparam logic [20:0] STEP_PER_HZ_RST = 21'd89478;

  // fixed-point constants
  localparam logic [33:0] LN2_Q30     = 34'd744261118;
  localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
  localparam logic [33:0] ONE_Q30     = 34'h0_4000_0000;
  localparam logic [33:0] FM_ONE_Q27  = 34'h0_0800_0000;
  localparam logic [31:0] SINE_AMP    = 32'd10240;
  localparam logic [65:0] SINE_RND    = 66'h0_2000_0000;
  localparam logic [36:0] FREQ_MIN    = 37'd2560;
  localparam logic [36:0] FREQ_MAX    = 37'd5120000;
  localparam logic [54:0] FREQ_CAP    = 55'h7FFF_FFFF;

  // floor division of signed values: add a multiple of the divisor first
  localparam logic [15:0] PM_DIV   = 16'd5;
  localparam logic [31:0] PM_RECIP = 32'(64'hFFFF_FFFF / 64'd5);
  localparam logic [33:0] PM_K     = 34'd429496730;
  localparam logic [33:0] PM_OFS   = 34'd2147483650;
  localparam logic [15:0] VM_DIV   = 16'd20480;
  localparam logic [31:0] VM_RECIP = 32'(64'hFFFF_FFFF / 64'd20480);
  localparam logic [33:0] VM_K     = 34'd104858;
  localparam logic [33:0] VM_OFS   = 34'd2147491840;

  // floor(32 * r / 5) for the remainder of the phase modulation divide
  localparam logic [5:0] PM_FRAC [5] = '{6'd0, 6'd6, 6'd12, 6'd19, 6'd25};

  // reciprocals of the exp2 series divisors 1..12
  localparam logic [31:0] EXP_RECIP [12] = '{
    32'(64'hFFFF_FFFF / 64'd1),  32'(64'hFFFF_FFFF / 64'd2),
    32'(64'hFFFF_FFFF / 64'd3),  32'(64'hFFFF_FFFF / 64'd4),
    32'(64'hFFFF_FFFF / 64'd5),  32'(64'hFFFF_FFFF / 64'd6),
    32'(64'hFFFF_FFFF / 64'd7),  32'(64'hFFFF_FFFF / 64'd8),
    32'(64'hFFFF_FFFF / 64'd9),  32'(64'hFFFF_FFFF / 64'd10),
    32'(64'hFFFF_FFFF / 64'd11), 32'(64'hFFFF_FFFF / 64'd12)
  };

  // sine series divisors (2j)(2j+1) and their reciprocals
  localparam logic [15:0] SIN_DIV [8] = '{
    16'd6, 16'd20, 16'd42, 16'd72, 16'd110, 16'd156, 16'd210, 16'd272
  };
  localparam logic [31:0] SIN_RECIP [8] = '{
    32'(64'hFFFF_FFFF / 64'd6),   32'(64'hFFFF_FFFF / 64'd20),
    32'(64'hFFFF_FFFF / 64'd42),  32'(64'hFFFF_FFFF / 64'd72),
    32'(64'hFFFF_FFFF / 64'd110), 32'(64'hFFFF_FFFF / 64'd156),
    32'(64'hFFFF_FFFF / 64'd210), 32'(64'hFFFF_FFFF / 64'd272)
  };

endpackage

// ===== rtl/wavetable_sine_vco_unit.sv =====
// Polyphonic sine oscillator. Each input beat is one sample tick of one voice and gives exactly
// one output beat with the same voice number. All arithmetic runs on one digit-serial
// multiplier (34 by 32 bits, one 8-bit digit of the second operand per cycle) under a
// sequencer; the exp2 and sine values are computed from their series for every
// sample, and divisions by constants are reciprocal products with a short correction loop. An
// item takes roughly 70 products plus correction steps from input beat to result; one item is
// in work at a time, and the next input beat is taken as soon as the result sits in the output
// register, even while that register still waits for out_ready.
// Voice phases reset to zero; a voice number at or above VOICES gives a zero sample and leaves
// all phases alone. cfg_ready is always high; registers should be written only while idle.
module wavetable_sine_vco_unit import wsv_pkg::*; #(
  parameter int VOICES       = VOICES_DEF,
  parameter int WAVE_ENTRIES = WAVE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         voice,
  input  logic signed [15:0] pitch_volts,
  input  logic signed [15:0] fm_volts,
  input  logic signed [15:0] pm_volts,
  input  logic signed [15:0] vm_volts,
  input  logic               fm_on,
  input  logic               pm_on,
  input  logic               vm_on,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_voice,
  output logic signed [15:0] sample_volts
);

  `include "wavetable_sine_vco_unit_macros.svh"

  localparam int VI_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int IDX_W = $clog2(WAVE_ENTRIES);
  localparam int M_W   = IDX_W + 1;
  localparam logic [33:0] WAVE_N     = 34'(WAVE_ENTRIES);
  localparam logic [31:0] SIN_A      = 32'(HALF_PI_Q30 / WAVE_N);
  localparam logic [31:0] SIN_B      = 32'(HALF_PI_Q30 % WAVE_N);
  localparam logic [31:0] WAVE_RECIP = 32'(64'hFFFF_FFFF / 64'(WAVE_ENTRIES));
  localparam logic [15:0] WAVE_DIV   = 16'(WAVE_ENTRIES);

  typedef enum logic [30:0] {
    ST_IDLE    = 31'h0000_0001,
    ST_MUL     = 31'h0000_0002,
    ST_DIV_B   = 31'h0000_0004,
    ST_DIV_C   = 31'h0000_0008,
    ST_DIV_FIX = 31'h0000_0010,
    ST_E_X     = 31'h0000_0020,
    ST_E_T     = 31'h0000_0040,
    ST_E_S     = 31'h0000_0080,
    ST_F_SH    = 31'h0000_0100,
    ST_F_FAC   = 31'h0000_0200,
    ST_F_FM    = 31'h0000_0400,
    ST_F_CLAMP = 31'h0000_0800,
    ST_P_ADD   = 31'h0000_1000,
    ST_P_DIV   = 31'h0000_2000,
    ST_P_SH    = 31'h0000_4000,
    ST_W_IDX   = 31'h0000_8000,
    ST_W_Q     = 31'h0001_0000,
    ST_W_XA    = 31'h0002_0000,
    ST_W_XB    = 31'h0004_0000,
    ST_W_XC    = 31'h0008_0000,
    ST_S_X2    = 31'h0010_0000,
    ST_S_T     = 31'h0020_0000,
    ST_S_S     = 31'h0040_0000,
    ST_S_RND   = 31'h0080_0000,
    ST_V_DIV   = 31'h0100_0000,
    ST_V_ADD   = 31'h0200_0000,
    ST_V_MUL   = 31'h0400_0000,
    ST_V_OUT   = 31'h0800_0000,
    ST_S_AMP   = 31'h1000_0000,
    ST_F_BASE  = 31'h2000_0000,
    ST_W_SPARE = 31'h4000_0000
  } state_t;

  // configuration registers
  logic [22:0] base_pitch;
  logic [16:0] phase_offset;
  logic [15:0] volume;
  logic [16:0] fm_depth, pm_depth, vm_depth;
  logic [20:0] step_per_hz;

  // sequencer and latched item
  state_t state, mul_ret, dv_ret;
  logic [3:0]         voice_r;
  logic signed [15:0] pv_r, fv_r, mv_r, vv_r;
  logic               fm_on_r, pm_on_r, vm_on_r;

  // serial multiplier
  logic signed [33:0] mul_a;
  logic [31:0]        mul_b;
  logic [1:0]         mul_cnt;
  logic signed [65:0] acc;
  logic signed [42:0] pp;

  // constant divider
  logic [33:0] dv_n, dv_q, dv_rem;
  logic [15:0] dv_d;

  // working values
  logic [3:0]         k;
  logic [31:0]        x_r;
  logic [33:0]        term;
  logic signed [33:0] sum;
  logic [36:0]        freq;
  logic [31:0]        tot;
  logic [1:0]         quad_r;
  logic [M_W-1:0]     m_r;
  logic [33:0]        xa;
  logic signed [15:0] rom;
  logic signed [19:0] vol;
  logic [31:0]        phases [VOICES];

  // combinational helpers
  logic [5:0]         sh_amt;
  logic [54:0]        fshift;
  logic [30:0]        fsat;
  logic signed [33:0] factor;
  logic [22:0]        fclamp;
  logic [31:0]        pnew;
  logic [VI_W-1:0]    vi;
  logic signed [33:0] pm_q;
  logic [31:0]        pm_add;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W+1:0]   u, rem_w;
  logic [1:0]         quad;
  logic [M_W-1:0]     m_w;
  logic [33:0]        xs;
  logic signed [33:0] sum_nx;
  logic [13:0]        s_amp;
  logic signed [65:0] s_rnd;
  logic signed [50:0] smp_full;
  logic signed [15:0] smp_sat;
  logic signed [33:0] fv_s, mv_s, vv_s, vol_s, rom_s;
  logic [31:0]        fm_mag, pm_mag, vm_mag, rom_mag;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign vi        = voice_r[VI_W-1:0];
  assign pp        = mul_a * $signed({1'b0, mul_b[31:24]});

  // operand signs and magnitudes
  always_comb begin
    fv_s    = 34'(fv_r);
    mv_s    = 34'(mv_r);
    vv_s    = 34'(vv_r);
    vol_s   = 34'(vol);
    rom_s   = 34'(rom);
    fm_mag  = fm_depth[16] ? 32'(-$signed(fm_depth)) : 32'(fm_depth);
    pm_mag  = pm_depth[16] ? 32'(-$signed(pm_depth)) : 32'(pm_depth);
    vm_mag  = vm_depth[16] ? 32'(-$signed(vm_depth)) : 32'(vm_depth);
    rom_mag = rom[15] ? 32'(-rom_s) : 32'(rom_s);
  end

  // frequency shaping
  always_comb begin
    sh_amt = 6'd30 - 6'($signed(pv_r[15:11]));
    fshift = acc[54:0] >> sh_amt;
    fsat   = (fshift > FREQ_CAP) ? 31'h7FFF_FFFF : fshift[30:0];
    factor = $signed(FM_ONE_Q27) + acc[33:0];
    if (freq < FREQ_MIN) begin
      fclamp = FREQ_MIN[22:0];
    end else if (freq > FREQ_MAX) begin
      fclamp = FREQ_MAX[22:0];
    end else begin
      fclamp = freq[22:0];
    end
  end

  // phase, table index and quadrant folding
  always_comb begin
    pnew   = phases[vi] + acc[39:8];
    pm_q   = $signed(dv_q) - $signed(PM_K);
    pm_add = 32'(pm_q <<< 5) + 32'(PM_FRAC[dv_rem[2:0]]);
    idx    = acc[IDX_W+31:32];
    u      = {idx, 2'b00};
    if (u >= (IDX_W+2)'(3 * WAVE_ENTRIES)) begin
      quad  = 2'd3;
      rem_w = u - (IDX_W+2)'(3 * WAVE_ENTRIES);
    end else if (u >= (IDX_W+2)'(2 * WAVE_ENTRIES)) begin
      quad  = 2'd2;
      rem_w = u - (IDX_W+2)'(2 * WAVE_ENTRIES);
    end else if (u >= (IDX_W+2)'(WAVE_ENTRIES)) begin
      quad  = 2'd1;
      rem_w = u - (IDX_W+2)'(WAVE_ENTRIES);
    end else begin
      quad  = 2'd0;
      rem_w = u;
    end
    m_w = quad[0] ? M_W'(WAVE_N) - M_W'(rem_w) : M_W'(rem_w);
    xs  = xa + dv_q;
  end

  // series accumulation, rounding and output saturation
  always_comb begin
    sum_nx   = k[0] ? (sum - $signed(dv_q)) : (sum + $signed(dv_q));
    s_rnd    = acc + $signed(SINE_RND);
    s_amp    = s_rnd[43:30];
    smp_full = acc[65:15];
    if (smp_full > 51'sd32767) begin
      smp_sat = 16'sh7FFF;
    end else if (smp_full < -51'sd32768) begin
      smp_sat = -16'sh8000;
    end else begin
      smp_sat = smp_full[15:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_pitch   <= BASE_PITCH_RST;
      phase_offset <= '0;
      volume       <= VOLUME_RST;
      fm_depth     <= '0;
      pm_depth     <= '0;
      vm_depth     <= '0;
      step_per_hz  <= STEP_PER_HZ_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_PITCH:   base_pitch   <= cfg_data;
        REG_PHASE_OFFSET: phase_offset <= cfg_data[16:0];
        REG_VOLUME:       volume       <= cfg_data[15:0];
        REG_FM_DEPTH:     fm_depth     <= cfg_data[16:0];
        REG_PM_DEPTH:     pm_depth     <= cfg_data[16:0];
        REG_VM_DEPTH:     vm_depth     <= cfg_data[16:0];
        REG_STEP_PER_HZ:  step_per_hz  <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  // voice phase accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        phases[i] <= '0;
      end
    end else if (state == ST_P_ADD) begin
      phases[vi] <= pnew;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_ret   <= ST_IDLE;
      dv_ret    <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            voice_r <= voice;
            pv_r    <= pitch_volts;
            fv_r    <= fm_volts;
            mv_r    <= pm_volts;
            vv_r    <= vm_volts;
            fm_on_r <= fm_on;
            pm_on_r <= pm_on;
            vm_on_r <= vm_on;
            if ({1'b0, voice} >= 5'(VOICES)) begin
              acc   <= '0;
              state <= ST_V_OUT;
            end else begin
              mul_a   <= {23'd0, pitch_volts[10:0]};
              mul_b   <= LN2_Q30[31:0];
              acc     <= '0;
              mul_cnt <= '0;
              mul_ret <= ST_E_X;
              state   <= ST_MUL;
            end
          end
        end
        // one 8-bit digit of mul_b per cycle, most significant first
        ST_MUL: begin
          acc     <= (acc <<< 8) + 66'(pp);
          mul_b   <= {mul_b[23:0], 8'd0};
          mul_cnt <= mul_cnt + 2'd1;
          if (mul_cnt == 2'd3) begin
            state <= mul_ret;
          end
        end
        // quotient estimate, then back-multiply for the remainder
        ST_DIV_B: begin
          dv_q    <= acc[65:32];
          mul_a   <= $signed(acc[65:32]);
          mul_b   <= {16'd0, dv_d};
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_DIV_C;
          state   <= ST_MUL;
        end
        ST_DIV_C: begin
          dv_rem <= dv_n - acc[33:0];
          state  <= ST_DIV_FIX;
        end
        ST_DIV_FIX: begin
          if (dv_rem >= {18'd0, dv_d}) begin
            dv_rem <= dv_rem - {18'd0, dv_d};
            dv_q   <= dv_q + 34'd1;
          end else begin
            state <= dv_ret;
          end
        end
        // exp2 of the pitch fraction
        ST_E_X: begin
          x_r     <= {2'b00, acc[40:11]};
          term    <= ONE_Q30;
          sum     <= $signed(ONE_Q30);
          k       <= 4'd1;
          mul_a   <= $signed(ONE_Q30);
          mul_b   <= {2'b00, acc[40:11]};
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_E_T;
          state   <= ST_MUL;
        end
        ST_E_T: begin
          dv_n    <= acc[63:30];
          dv_d    <= 16'(k);
          dv_ret  <= ST_E_S;
          mul_a   <= $signed(acc[63:30]);
          mul_b   <= EXP_RECIP[4'(k - 4'd1)];
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_DIV_B;
          state   <= ST_MUL;
        end
        ST_E_S: begin
          term <= dv_q;
          sum  <= sum + $signed(dv_q);
          if (k == 4'd12) begin
            state <= ST_F_BASE;
          end else begin
            k       <= k + 4'd1;
            mul_a   <= $signed(dv_q);
            mul_b   <= x_r;
            acc     <= '0;
            mul_cnt <= '0;
            mul_ret <= ST_E_T;
            state   <= ST_MUL;
          end
        end
        // base pitch times exp2, then octave shift
        ST_F_BASE: begin
          mul_a   <= sum;
          mul_b   <= {9'd0, base_pitch};
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_F_SH;
          state   <= ST_MUL;
        end
        ST_F_SH: begin
          freq <= {6'd0, fsat};
          if (fm_on_r) begin
            mul_a   <= fm_depth[16] ? -fv_s : fv_s;
            mul_b   <= fm_mag;
            acc     <= '0;
            mul_cnt <= '0;
            mul_ret <= ST_F_FAC;
            state   <= ST_MUL;
          end else begin
            state <= ST_F_CLAMP;
          end
        end
        ST_F_FAC: begin
          if (factor <= 34'sd0) begin
            freq  <= '0;
            state <= ST_F_CLAMP;
          end else begin
            mul_a   <= $signed({3'b000, freq[30:0]});
            mul_b   <= factor[31:0];
            acc     <= '0;
            mul_cnt <= '0;
            mul_ret <= ST_F_FM;
            state   <= ST_MUL;
          end
        end
        ST_F_FM: begin
          freq  <= acc[63:27];
          state <= ST_F_CLAMP;
        end
        ST_F_CLAMP: begin
          mul_a   <= $signed({11'd0, fclamp});
          mul_b   <= {11'd0, step_per_hz};
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_P_ADD;
          state   <= ST_MUL;
        end
        // phase advance and phase shift
        ST_P_ADD: begin
          tot <= pnew + {phase_offset[15:0], 16'd0};
          if (pm_on_r) begin
            mul_a   <= pm_depth[16] ? -mv_s : mv_s;
            mul_b   <= pm_mag;
            acc     <= '0;
            mul_cnt <= '0;
            mul_ret <= ST_P_DIV;
            state   <= ST_MUL;
          end else begin
            state <= ST_W_IDX;
          end
        end
        ST_P_DIV: begin
          dv_n    <= acc[33:0] + PM_OFS;
          dv_d    <= PM_DIV;
          dv_ret  <= ST_P_SH;
          mul_a   <= $signed(acc[33:0] + PM_OFS);
          mul_b   <= PM_RECIP;
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_DIV_B;
          state   <= ST_MUL;
        end
        ST_P_SH: begin
          tot   <= tot + pm_add;
          state <= ST_W_IDX;
        end
        // table index and angle of the folded quarter wave
        ST_W_IDX: begin
          mul_a   <= $signed(WAVE_N);
          mul_b   <= tot;
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_W_Q;
          state   <= ST_MUL;
        end
        ST_W_Q: begin
          quad_r  <= quad;
          m_r     <= m_w;
          mul_a   <= 34'(m_w);
          mul_b   <= SIN_A;
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_W_XA;
          state   <= ST_MUL;
        end
        ST_W_XA: begin
          xa      <= acc[33:0];
          mul_a   <= 34'(m_r);
          mul_b   <= SIN_B;
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_W_XB;
          state   <= ST_MUL;
        end
        ST_W_XB: begin
          dv_n    <= acc[33:0];
          dv_d    <= WAVE_DIV;
          dv_ret  <= ST_W_XC;
          mul_a   <= $signed(acc[33:0]);
          mul_b   <= WAVE_RECIP;
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_DIV_B;
          state   <= ST_MUL;
        end
        ST_W_XC: begin
          term    <= xs;
          sum     <= $signed(xs);
          k       <= 4'd1;
          mul_a   <= $signed(xs);
          mul_b   <= xs[31:0];
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_S_X2;
          state   <= ST_MUL;
        end
        // sine series
        ST_S_X2: begin
          x_r     <= acc[61:30];
          mul_a   <= $signed(term);
          mul_b   <= acc[61:30];
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_S_T;
          state   <= ST_MUL;
        end
        ST_S_T: begin
          dv_n    <= acc[63:30];
          dv_d    <= SIN_DIV[3'(k - 4'd1)];
          dv_ret  <= ST_S_S;
          mul_a   <= $signed(acc[63:30]);
          mul_b   <= SIN_RECIP[3'(k - 4'd1)];
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_DIV_B;
          state   <= ST_MUL;
        end
        ST_S_S: begin
          term <= dv_q;
          sum  <= sum_nx;
          if (k == 4'd8) begin
            state <= ST_S_AMP;
          end else begin
            k       <= k + 4'd1;
            mul_a   <= $signed(dv_q);
            mul_b   <= x_r;
            acc     <= '0;
            mul_cnt <= '0;
            mul_ret <= ST_S_T;
            state   <= ST_MUL;
          end
        end
        ST_S_AMP: begin
          mul_a   <= (sum < 34'sd0) ? 34'sd0 : sum;
          mul_b   <= SINE_AMP;
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_S_RND;
          state   <= ST_MUL;
        end
        // rounded table value, then volume
        ST_S_RND: begin
          rom <= quad_r[1] ? -$signed({2'b00, s_amp}) : $signed({2'b00, s_amp});
          if (vm_on_r) begin
            mul_a   <= vm_depth[16] ? -vv_s : vv_s;
            mul_b   <= vm_mag;
            acc     <= '0;
            mul_cnt <= '0;
            mul_ret <= ST_V_DIV;
            state   <= ST_MUL;
          end else begin
            vol   <= $signed({4'd0, volume});
            state <= ST_V_MUL;
          end
        end
        ST_V_DIV: begin
          dv_n    <= acc[33:0] + VM_OFS;
          dv_d    <= VM_DIV;
          dv_ret  <= ST_V_ADD;
          mul_a   <= $signed(acc[33:0] + VM_OFS);
          mul_b   <= VM_RECIP;
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_DIV_B;
          state   <= ST_MUL;
        end
        ST_V_ADD: begin
          vol   <= $signed({4'd0, volume}) + 20'($signed(dv_q) - $signed(VM_K));
          state <= ST_V_MUL;
        end
        ST_V_MUL: begin
          mul_a   <= rom[15] ? -vol_s : vol_s;
          mul_b   <= rom_mag;
          acc     <= '0;
          mul_cnt <= '0;
          mul_ret <= ST_V_OUT;
          state   <= ST_MUL;
        end
        // result into the output register once it is free
        ST_V_OUT: begin
          if (!out_valid || out_ready) begin
            out_voice    <= voice_r;
            sample_volts <= smp_sat;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        ST_W_SPARE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `WSV_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state != ST_IDLE)
  `WSV_ASSERT_IMP(a_fix_bounded, state == ST_DIV_FIX, dv_rem < {15'd0, dv_d, 3'd0})
  `WSV_ASSERT_NXT(a_result_waits, state == ST_V_OUT && out_valid && !out_ready,
                  state == ST_V_OUT)
  `WSV_ASSERT_IMP(a_mul_returns, state == ST_MUL, mul_ret != ST_MUL)

endmodule
